### sv/mmf_pkg.sv
`timescale 1ns / 1ps

package mmf_pkg;

    localparam int RING_DEPTH    = 512;
    localparam int MESSAGE_BYTES = 512;

    localparam int LANES    = 8;
    localparam int DATA_W   = 64;
    localparam int CNT_W    = 4;
    localparam int REQ_W    = 10;
    localparam int TOTAL_W  = 10;
    localparam int STATUS_W = 2;

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int PTR_W  = $clog2(2 * RING_DEPTH);
    localparam int LEN_W  = $clog2(MESSAGE_BYTES + 1);
    localparam int OFF_W  = ($clog2(MESSAGE_BYTES) > 3) ? $clog2(MESSAGE_BYTES) : 4;
    localparam int ROW_W  = SLOT_W + OFF_W - 3;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_TRUNC = 2'd3;

    typedef struct packed {
        logic              len_en;
        logic              off_en;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  off;
    } tbl_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  offset;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] data;
    } byte_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  offset;
    } byte_rd_t;

endpackage

### sv/mmf_byte_store.sv
`timescale 1ns / 1ps

module mmf_byte_store (
    input  logic                           aclk,
    input  mmf_pkg::byte_wr_t              wr,
    input  mmf_pkg::byte_rd_t              rd,
    output logic [mmf_pkg::DATA_W-1:0]     rd_data
);

    localparam int BANK_DEPTH = 2 ** mmf_pkg::ROW_W;

    logic [mmf_pkg::DATA_W-1:0] bank_flat;
    logic [2:0]                 rd_lane_reg;

    for (genvar l = 0; l < mmf_pkg::LANES; l++) begin : g_lane
        logic [2:0]                 wj;
        logic [mmf_pkg::LEN_W:0]    wsum;
        logic                       wen;
        logic [mmf_pkg::ROW_W-1:0]  wrow;
        logic [7:0]                 wbyte;
        logic [2:0]                 rj;
        logic [mmf_pkg::LEN_W:0]    rsum;
        logic [mmf_pkg::ROW_W-1:0]  rrow;
        logic [7:0]                 q_reg;
        logic [7:0]                 mem [BANK_DEPTH];

        always_comb begin
            wj    = 3'(l) - wr.offset[2:0];
            wsum  = (mmf_pkg::LEN_W+1)'(wr.offset) + (mmf_pkg::LEN_W+1)'(wj);
            wen   = wr.en && ({1'b0, wj} < wr.count)
                    && (wsum < (mmf_pkg::LEN_W+1)'(mmf_pkg::MESSAGE_BYTES));
            wrow  = {wr.slot, wsum[mmf_pkg::OFF_W-1:3]};
            wbyte = wr.data[{wj, 3'b000} +: 8];
            rj    = 3'(l) - rd.offset[2:0];
            rsum  = (mmf_pkg::LEN_W+1)'(rd.offset) + (mmf_pkg::LEN_W+1)'(rj);
            rrow  = {rd.slot, rsum[mmf_pkg::OFF_W-1:3]};
        end

        always_ff @(posedge aclk) begin
            if (wen) begin
                mem[wrow] <= wbyte;
            end
            if (rd.en) begin
                q_reg <= mem[rrow];
            end
        end

        assign bank_flat[8*l +: 8] = q_reg;
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_lane_reg <= rd.offset[2:0];
        end
    end

    always_comb begin
        logic [2:0] lane;
        rd_data = '0;
        for (int j = 0; j < mmf_pkg::LANES; j++) begin
            lane = rd_lane_reg + 3'(j);
            rd_data[8*j +: 8] = bank_flat[{lane, 3'b000} +: 8];
        end
    end

endmodule

### sv/mmf_slot_table.sv
`timescale 1ns / 1ps

module mmf_slot_table (
    input  logic                          aclk,
    input  mmf_pkg::tbl_wr_t              wr,
    input  logic                          rd_en,
    input  logic [mmf_pkg::SLOT_W-1:0]    rd_slot,
    output logic [mmf_pkg::LEN_W-1:0]     rd_len,
    output logic [mmf_pkg::LEN_W-1:0]     rd_off
);

    logic [mmf_pkg::LEN_W-1:0] mem_len [mmf_pkg::RING_DEPTH];
    logic [mmf_pkg::LEN_W-1:0] mem_off [mmf_pkg::RING_DEPTH];
    logic [mmf_pkg::LEN_W-1:0] rd_len_reg;
    logic [mmf_pkg::LEN_W-1:0] rd_off_reg;

    always_ff @(posedge aclk) begin
        if (wr.len_en) begin
            mem_len[wr.slot] <= wr.len;
        end
        if (wr.off_en) begin
            mem_off[wr.slot] <= wr.off;
        end
        if (rd_en) begin
            rd_len_reg <= mem_len[rd_slot];
            rd_off_reg <= mem_off[rd_slot];
        end
    end

    assign rd_len = rd_len_reg;
    assign rd_off = rd_off_reg;

endmodule

### sv/message_mailbox_fifo.sv
// Message mailbox: a ring of message slots fed and drained over two
// valid/ready channels (s_ for items in, m_ for results out).
// A send item carries one chunk of up to eight bytes; the chunk flagged
// last commits the message at the tail. Each send gives one result, with
// status ok, full (message dropped) or truncated.
// A receive item asks for up to request_length bytes of the head message
// and returns them up to eight bytes per result, from its read offset on.
// A send or an empty-ring receive shows its result in the cycle after
// the transfer. A receive looks up length and offset in the slot table,
// then moves one word per cycle out of the eight byte banks while the
// receiver takes results; the first word passes the slot table read
// register, a byte bank read register and the output register.
// After a send the block takes a new item once the output register is
// free; a receive takes no new item until its last word is registered.
// Reset clears the state, the ring pointers, the message assembly state
// and the output valid flag; the memories need no clearing pass.
// When the receiver stalls, the result holds in the output register and
// the block takes no new word or item until that result is transferred.
`timescale 1ns / 1ps

module message_mailbox_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [mmf_pkg::DATA_W-1:0]        s_chunk_data,
    input  logic [mmf_pkg::CNT_W-1:0]         s_chunk_bytes,
    input  logic                              s_chunk_last,
    input  logic [mmf_pkg::REQ_W-1:0]         s_request_length,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mmf_pkg::DATA_W-1:0]        m_out_data,
    output logic [mmf_pkg::CNT_W-1:0]         m_out_bytes,
    output logic                              m_out_last,
    output logic [mmf_pkg::STATUS_W-1:0]      m_status,
    output logic [mmf_pkg::TOTAL_W-1:0]       m_read_total,
    output logic                              m_message_done
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    localparam int PW = mmf_pkg::PTR_W;
    localparam int SW = mmf_pkg::SLOT_W;
    localparam int LW = mmf_pkg::LEN_W;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PW'(2 * mmf_pkg::RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SW-1:0] ptr_slot(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = (p >= PW'(mmf_pkg::RING_DEPTH)) ? p - PW'(mmf_pkg::RING_DEPTH) : p;
        return s[SW-1:0];
    endfunction

    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [LW-1:0] asm_len_reg, asm_len_next;
    logic          asm_drop_reg, asm_drop_next;
    logic          asm_trunc_reg, asm_trunc_next;
    logic          m_valid_reg, m_valid_next;

    logic [mmf_pkg::REQ_W-1:0]    req_reg, req_next;
    logic [SW-1:0]                slot_reg, slot_next;
    logic [LW-1:0]                cur_reg, cur_next;
    logic [LW-1:0]                rem_reg, rem_next;
    logic [LW-1:0]                total_reg, total_next;
    logic                         done_reg, done_next;
    logic [mmf_pkg::DATA_W-1:0]   out_data_reg, out_data_next;
    logic [mmf_pkg::CNT_W-1:0]    out_bytes_reg, out_bytes_next;
    logic                         out_last_reg, out_last_next;
    logic [mmf_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [mmf_pkg::TOTAL_W-1:0]  read_total_reg, read_total_next;
    logic                         message_done_reg, message_done_next;

    logic [SW-1:0]                head_slot, tail_slot;
    logic                         empty, full, out_free, accept;
    logic [mmf_pkg::CNT_W-1:0]    n_clamp;
    logic                         start, drop_eff, trunc_eff;
    logic [LW:0]                  sum;
    logic [LW-1:0]                new_len;
    logic [LW-1:0]                tbl_len, tbl_off;
    logic [LW-1:0]                left, rd_calc;
    logic                         rd_done;
    logic [mmf_pkg::CNT_W-1:0]    cnt;
    logic                         emit_last;
    logic [mmf_pkg::DATA_W-1:0]   bank_word, out_word;

    mmf_pkg::tbl_wr_t  tbl_wr;
    mmf_pkg::byte_wr_t byte_wr;
    mmf_pkg::byte_rd_t byte_rd;
    logic              tbl_rd_en;

    mmf_slot_table u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd_en   (tbl_rd_en),
        .rd_slot (head_slot),
        .rd_len  (tbl_len),
        .rd_off  (tbl_off)
    );

    mmf_byte_store u_bytes (
        .aclk    (aclk),
        .wr      (byte_wr),
        .rd      (byte_rd),
        .rd_data (bank_word)
    );

    always_comb begin
        head_slot = ptr_slot(head_reg);
        tail_slot = ptr_slot(tail_reg);
        empty     = (head_reg == tail_reg);
        full      = (head_slot == tail_slot) && !empty;
        out_free  = !m_valid_reg || m_ready;
        s_ready   = (state_reg == ST_IDLE) && out_free;
        accept    = s_valid && s_ready;

        n_clamp   = s_chunk_bytes[3] ? mmf_pkg::CNT_W'(mmf_pkg::LANES) : s_chunk_bytes;
        start     = (asm_len_reg == '0) && !asm_drop_reg && !asm_trunc_reg;
        drop_eff  = asm_drop_reg || (start && full);
        sum       = (LW+1)'(asm_len_reg) + (LW+1)'(n_clamp);
        if (drop_eff) begin
            new_len   = asm_len_reg;
            trunc_eff = asm_trunc_reg;
        end else if (sum > (LW+1)'(mmf_pkg::MESSAGE_BYTES)) begin
            new_len   = LW'(mmf_pkg::MESSAGE_BYTES);
            trunc_eff = 1'b1;
        end else begin
            new_len   = sum[LW-1:0];
            trunc_eff = asm_trunc_reg;
        end

        left    = (tbl_len > tbl_off) ? tbl_len - tbl_off : '0;
        rd_done = (mmf_pkg::REQ_W'(left) <= req_reg);
        rd_calc = rd_done ? left : req_reg[LW-1:0];

        emit_last = (rem_reg <= LW'(mmf_pkg::LANES));
        cnt = emit_last ? mmf_pkg::CNT_W'(rem_reg) : mmf_pkg::CNT_W'(mmf_pkg::LANES);
        for (int j = 0; j < mmf_pkg::LANES; j++) begin
            out_word[8*j +: 8] = (mmf_pkg::CNT_W'(j) < cnt) ? bank_word[8*j +: 8] : 8'd0;
        end

        tbl_rd_en = accept && (s_op == mmf_pkg::OP_RECV);

        byte_wr.en     = accept && (s_op == mmf_pkg::OP_SEND) && !drop_eff;
        byte_wr.slot   = tail_slot;
        byte_wr.offset = asm_len_reg;
        byte_wr.count  = n_clamp;
        byte_wr.data   = s_chunk_data;

        byte_rd.en     = (state_reg == ST_LOOKUP)
                         || ((state_reg == ST_EMIT) && out_free && !emit_last);
        byte_rd.slot   = slot_reg;
        byte_rd.offset = (state_reg == ST_LOOKUP) ? tbl_off
                         : cur_reg + LW'(mmf_pkg::LANES);

        tbl_wr.len_en = byte_wr.en && s_chunk_last;
        tbl_wr.off_en = tbl_wr.len_en || ((state_reg == ST_LOOKUP) && !rd_done);
        tbl_wr.slot   = (state_reg == ST_LOOKUP) ? slot_reg : tail_slot;
        tbl_wr.len    = new_len;
        tbl_wr.off    = (state_reg == ST_LOOKUP) ? tbl_off + rd_calc : '0;
    end

    always_comb begin
        state_next        = state_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        asm_len_next      = asm_len_reg;
        asm_drop_next     = asm_drop_reg;
        asm_trunc_next    = asm_trunc_reg;
        m_valid_next      = m_ready ? 1'b0 : m_valid_reg;
        req_next          = req_reg;
        slot_next         = slot_reg;
        cur_next          = cur_reg;
        rem_next          = rem_reg;
        total_next        = total_reg;
        done_next         = done_reg;
        out_data_next     = out_data_reg;
        out_bytes_next    = out_bytes_reg;
        out_last_next     = out_last_reg;
        status_next       = status_reg;
        read_total_next   = read_total_reg;
        message_done_next = message_done_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_op == mmf_pkg::OP_SEND)) begin
                    m_valid_next      = 1'b1;
                    out_data_next     = '0;
                    out_bytes_next    = '0;
                    out_last_next     = 1'b1;
                    read_total_next   = '0;
                    message_done_next = 1'b0;
                    status_next       = drop_eff ? mmf_pkg::STAT_FULL
                                        : (trunc_eff ? mmf_pkg::STAT_TRUNC : mmf_pkg::STAT_OK);
                    if (s_chunk_last) begin
                        if (!drop_eff) begin
                            tail_next = ptr_next(tail_reg);
                        end
                        asm_len_next   = '0;
                        asm_drop_next  = 1'b0;
                        asm_trunc_next = 1'b0;
                    end else begin
                        asm_len_next   = new_len;
                        asm_drop_next  = drop_eff;
                        asm_trunc_next = trunc_eff;
                    end
                end else if (accept) begin
                    if (empty) begin
                        m_valid_next      = 1'b1;
                        out_data_next     = '0;
                        out_bytes_next    = '0;
                        out_last_next     = 1'b1;
                        read_total_next   = '0;
                        message_done_next = 1'b0;
                        status_next       = mmf_pkg::STAT_EMPTY;
                    end else begin
                        slot_next  = head_slot;
                        req_next   = s_request_length;
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: begin
                cur_next   = tbl_off;
                rem_next   = rd_calc;
                total_next = rd_calc;
                done_next  = rd_done;
                if (rd_done) begin
                    head_next = ptr_next(head_reg);
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    out_data_next     = out_word;
                    out_bytes_next    = cnt;
                    out_last_next     = emit_last;
                    status_next       = mmf_pkg::STAT_OK;
                    read_total_next   = mmf_pkg::TOTAL_W'(total_reg);
                    message_done_next = done_reg;
                    cur_next          = cur_reg + LW'(cnt);
                    rem_next          = rem_reg - LW'(cnt);
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            asm_len_reg   <= '0;
            asm_drop_reg  <= 1'b0;
            asm_trunc_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            asm_len_reg   <= asm_len_next;
            asm_drop_reg  <= asm_drop_next;
            asm_trunc_reg <= asm_trunc_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg          <= req_next;
        slot_reg         <= slot_next;
        cur_reg          <= cur_next;
        rem_reg          <= rem_next;
        total_reg        <= total_next;
        done_reg         <= done_next;
        out_data_reg     <= out_data_next;
        out_bytes_reg    <= out_bytes_next;
        out_last_reg     <= out_last_next;
        status_reg       <= status_next;
        read_total_reg   <= read_total_next;
        message_done_reg <= message_done_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_data     = out_data_reg;
    assign m_out_bytes    = out_bytes_reg;
    assign m_out_last     = out_last_reg;
    assign m_status       = status_reg;
    assign m_read_total   = read_total_reg;
    assign m_message_done = message_done_reg;

    a_no_commit_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_op == mmf_pkg::OP_SEND) && s_chunk_last && start && full)
        |=> $stable(tail_reg))
        else $error("message committed into a full ring");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_op == mmf_pkg::OP_RECV) && empty)
        |=> (m_valid && (m_status == mmf_pkg::STAT_EMPTY) && m_out_last))
        else $error("empty ring receive gave no empty status");

    a_full_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_out_last) |-> (m_out_bytes == mmf_pkg::CNT_W'(mmf_pkg::LANES)))
        else $error("short word before the last result of a receive");

    a_data_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_out_bytes != '0)) |-> (m_status == mmf_pkg::STAT_OK))
        else $error("read bytes carry a non-ok status");

endmodule

### tb/mailbox_check.sv
`timescale 1ns / 1ps

module mailbox_check
    import mmf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                s_op,
    input  logic [DATA_W-1:0]   s_chunk_data,
    input  logic [CNT_W-1:0]    s_chunk_bytes,
    input  logic                s_chunk_last,
    input  logic [REQ_W-1:0]    s_request_length,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [DATA_W-1:0]   m_out_data,
    input  logic [CNT_W-1:0]    m_out_bytes,
    input  logic                m_out_last,
    input  logic [STATUS_W-1:0] m_status,
    input  logic [TOTAL_W-1:0]  m_read_total,
    input  logic                m_message_done,
    output int unsigned         fault_count,
    output int unsigned         owed_count
);

    typedef struct packed {
        logic [DATA_W-1:0]   data;
        logic [CNT_W-1:0]    bytes;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  total;
        logic                done;
    } mbx_word_t;

    logic [7:0]  byte_store [RING_DEPTH*MESSAGE_BYTES];
    int unsigned slot_len [RING_DEPTH];
    int unsigned slot_off [RING_DEPTH];
    int unsigned head_ptr;
    int unsigned tail_ptr;
    int unsigned asm_len;
    bit          asm_drop;
    bit          asm_trunc;
    mbx_word_t   owed_words [$];

    function automatic int unsigned ptr_bump(input int unsigned p);
        return (p + 1 == 2 * RING_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int unsigned ring_fill();
        return (tail_ptr + 2 * RING_DEPTH - head_ptr) % (2 * RING_DEPTH);
    endfunction

    task automatic report(input string note);
        $display("%0t mailbox_check: %s", $time, note);
        fault_count++;
    endtask

    task automatic owe(input logic [DATA_W-1:0] d, input int unsigned b, input logic l,
                       input logic [STATUS_W-1:0] st, input int unsigned tot,
                       input logic dn);
        mbx_word_t w;
        w.data   = d;
        w.bytes  = b[CNT_W-1:0];
        w.last   = l;
        w.status = st;
        w.total  = tot[TOTAL_W-1:0];
        w.done   = dn;
        owed_words.push_back(w);
    endtask

    task automatic mailbox_step(input logic op, input logic [DATA_W-1:0] data,
                                input logic [CNT_W-1:0] nb, input logic lst,
                                input logic [REQ_W-1:0] req);
        int unsigned         n;
        int unsigned         slot;
        int unsigned         left;
        int unsigned         rd;
        int unsigned         nres;
        int unsigned         pos;
        int unsigned         cnt;
        int unsigned         idx;
        int unsigned         off;
        logic                dn;
        logic [STATUS_W-1:0] st;
        logic [DATA_W-1:0]   w;
        if (op == OP_SEND) begin
            n = (nb > LANES) ? LANES : nb;
            slot = tail_ptr % RING_DEPTH;
            if (asm_len == 0 && !asm_drop && !asm_trunc && ring_fill() >= RING_DEPTH) begin
                asm_drop = 1'b1;
            end
            if (!asm_drop) begin
                for (int i = 0; i < n; i++) begin
                    if (asm_len < MESSAGE_BYTES) begin
                        byte_store[slot*MESSAGE_BYTES + asm_len] = data[8*i +: 8];
                        asm_len++;
                    end else begin
                        asm_trunc = 1'b1;
                    end
                end
            end
            st = asm_drop ? STAT_FULL : (asm_trunc ? STAT_TRUNC : STAT_OK);
            if (lst) begin
                if (!asm_drop) begin
                    slot_len[slot] = asm_len;
                    slot_off[slot] = 0;
                    tail_ptr = ptr_bump(tail_ptr);
                end
                asm_len   = 0;
                asm_drop  = 1'b0;
                asm_trunc = 1'b0;
            end
            owe('0, 0, 1'b1, st, 0, 1'b0);
        end else if (head_ptr == tail_ptr) begin
            owe('0, 0, 1'b1, STAT_EMPTY, 0, 1'b0);
        end else begin
            slot = head_ptr % RING_DEPTH;
            off  = slot_off[slot];
            left = (slot_len[slot] > off) ? slot_len[slot] - off : 0;
            rd   = (req < left) ? req : left;
            dn   = (rd == left);
            nres = (rd + 7) / 8;
            if (nres == 0) begin
                owe('0, 0, 1'b1, STAT_OK, rd, dn);
            end else begin
                pos = 0;
                for (int k = 0; k < nres; k++) begin
                    cnt = (rd - pos > LANES) ? LANES : rd - pos;
                    w = '0;
                    for (int i = 0; i < cnt; i++) begin
                        idx = off + pos + i;
                        if (idx < MESSAGE_BYTES) begin
                            w[8*i +: 8] = byte_store[slot*MESSAGE_BYTES + idx];
                        end
                    end
                    owe(w, cnt, (k + 1 == nres), STAT_OK, rd, dn);
                    pos += cnt;
                end
            end
            if (dn) begin
                head_ptr = ptr_bump(head_ptr);
            end else begin
                slot_off[slot] = off + rd;
            end
        end
    endtask

    task automatic match_word();
        mbx_word_t want;
        if (owed_words.size() == 0) begin
            report($sformatf("result with nothing owed: data %h bytes %0d status %0d",
                             m_out_data, m_out_bytes, m_status));
        end else begin
            want = owed_words.pop_front();
            if (m_out_data !== want.data)
                report($sformatf("out_data %h, want %h", m_out_data, want.data));
            if (m_out_bytes !== want.bytes)
                report($sformatf("out_bytes %0d, want %0d", m_out_bytes, want.bytes));
            if (m_out_last !== want.last)
                report($sformatf("out_last %b, want %b", m_out_last, want.last));
            if (m_status !== want.status)
                report($sformatf("status %0d, want %0d", m_status, want.status));
            if (m_read_total !== want.total)
                report($sformatf("read_total %0d, want %0d", m_read_total, want.total));
            if (m_message_done !== want.done)
                report($sformatf("message_done %b, want %b", m_message_done, want.done));
        end
    endtask

    // check outgoing transfer before predicting the incoming one of the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            head_ptr    = 0;
            tail_ptr    = 0;
            asm_len     = 0;
            asm_drop    = 1'b0;
            asm_trunc   = 1'b0;
            fault_count = 0;
        end else begin
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                match_word();
            end
            if (s_valid === 1'b1 && s_ready === 1'b1) begin
                mailbox_step(s_op, s_chunk_data, s_chunk_bytes, s_chunk_last,
                             s_request_length);
            end
        end
        owed_count <= owed_words.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import mmf_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_op;
    logic [DATA_W-1:0]   s_chunk_data;
    logic [CNT_W-1:0]    s_chunk_bytes;
    logic                s_chunk_last;
    logic [REQ_W-1:0]    s_request_length;
    logic                m_valid;
    logic                m_ready;
    logic [DATA_W-1:0]   m_out_data;
    logic [CNT_W-1:0]    m_out_bytes;
    logic                m_out_last;
    logic [STATUS_W-1:0] m_status;
    logic [TOTAL_W-1:0]  m_read_total;
    logic                m_message_done;

    int unsigned fault_count;
    int unsigned owed_count;
    int          tx_idle_pct = 24;
    int          rx_idle_pct = 84;
    bit          hold_req = 1'b0;
    bit          hold_taken = 1'b0;
    int          quiet_run = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    message_mailbox_fifo DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_chunk_data     (s_chunk_data),
        .s_chunk_bytes    (s_chunk_bytes),
        .s_chunk_last     (s_chunk_last),
        .s_request_length (s_request_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_data       (m_out_data),
        .m_out_bytes      (m_out_bytes),
        .m_out_last       (m_out_last),
        .m_status         (m_status),
        .m_read_total     (m_read_total),
        .m_message_done   (m_message_done)
    );

    mailbox_check u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_chunk_data     (s_chunk_data),
        .s_chunk_bytes    (s_chunk_bytes),
        .s_chunk_last     (s_chunk_last),
        .s_request_length (s_request_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_data       (m_out_data),
        .m_out_bytes      (m_out_bytes),
        .m_out_last       (m_out_last),
        .m_status         (m_status),
        .m_read_total     (m_read_total),
        .m_message_done   (m_message_done),
        .fault_count      (fault_count),
        .owed_count       (owed_count)
    );

    // hold off the result channel on request, else stall at random
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_run <= 0;
        end else if (quiet_run >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            quiet_run <= quiet_run + 1;
        end
    end

    task automatic offer(input logic op, input logic [DATA_W-1:0] data,
                         input logic [CNT_W-1:0] nb, input logic lst,
                         input logic [REQ_W-1:0] req);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_op             <= op;
        s_chunk_data     <= data;
        s_chunk_bytes    <= nb;
        s_chunk_last     <= lst;
        s_request_length <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_chunk(input logic [CNT_W-1:0] nb, input logic lst);
        offer(OP_SEND, {$urandom, $urandom}, nb, lst, REQ_W'($urandom_range(512)));
    endtask

    task automatic ask(input logic [REQ_W-1:0] req);
        offer(OP_RECV, {$urandom, $urandom}, CNT_W'($urandom_range(15)),
              1'($urandom_range(1)), req);
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        else if (r < 18)
            return CNT_W'($urandom_range(15, 9));
        else
            return CNT_W'($urandom_range(8, 1));
    endfunction

    function automatic logic [REQ_W-1:0] pick_request();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        else if (r < 22)
            return REQ_W'(MESSAGE_BYTES);
        else if (r < 35)
            return REQ_W'($urandom_range(MESSAGE_BYTES));
        else
            return REQ_W'($urandom_range(24, 1));
    endfunction

    task automatic random_traffic(input int items);
        int issued;
        int r;
        int k;
        issued = 0;
        while (issued < items) begin
            r = $urandom_range(99);
            if (r < 45) begin
                k = $urandom_range(6, 1);
                for (int i = 0; i < k; i++) send_chunk(pick_count(), i == k - 1);
                issued += k;
            end else if (r < 82) begin
                ask(pick_request());
                issued++;
            end else if (r < 98) begin
                send_chunk(pick_count(), 1'($urandom_range(1)));
                issued++;
            end else begin
                // full-size or oversize message
                k = $urandom_range(70, 64);
                for (int i = 0; i < k; i++) begin
                    send_chunk(CNT_W'($urandom_range(15, 8)), i == k - 1);
                end
                issued += k;
            end
        end
    endtask

    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_op             = OP_SEND;
        s_chunk_data     = '0;
        s_chunk_bytes    = '0;
        s_chunk_last     = 1'b0;
        s_request_length = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        ask(REQ_W'(MESSAGE_BYTES));
        offer(OP_SEND, '1, CNT_W'(8), 1'b0, '0);
        offer(OP_SEND, '0, '0, 1'b0, REQ_W'(MESSAGE_BYTES));
        offer(OP_SEND, 64'h0123_4567_89ab_cdef, '1, 1'b0, '0);
        offer(OP_SEND, 64'ha5a5_5a5a_c3c3_3c3c, CNT_W'(3), 1'b1, '0);
        ask('0);
        ask(REQ_W'(5));
        ask(REQ_W'(MESSAGE_BYTES));
        send_chunk('0, 1'b1);
        ask(REQ_W'(10));
        ask(REQ_W'(1));
        send_chunk(CNT_W'(2), 1'b1);
        ask(REQ_W'(2));
        offer(OP_RECV, '1, '1, 1'b1, REQ_W'(MESSAGE_BYTES));

        random_traffic(130);

        tx_idle_pct = 84;
        rx_idle_pct = 24;
        random_traffic(130);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        random_traffic(40);
        random_traffic(90);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (owed_count != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fault_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
